[design/cubic_convolution_line_sampler_assert.svh]
`ifndef CUBIC_CONVOLUTION_LINE_SAMPLER_ASSERT_SVH
`define CUBIC_CONVOLUTION_LINE_SAMPLER_ASSERT_SVH

// Check that a condition implies another in the same cycle, outside reset.
`define CCLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccls assertion failed");

// Check that a condition implies another in the following cycle, outside reset.
`define CCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccls assertion failed");

`endif

[design/ccls_pkg.sv]
package ccls_pkg;

    // Storage and fixed-point format
    localparam int MAX_SAMPLES   = 1024;
    localparam int FRACTION_BITS = 16;
    localparam int ADDR_W        = $clog2(MAX_SAMPLES);

    // Field widths
    localparam int POS_W    = 32;
    localparam int INT_W    = POS_W - FRACTION_BITS;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 11;
    localparam int WIDX_W   = 10;

    // Datapath widths
    localparam int CMP_W  = INT_W + 2;
    localparam int WGT_W  = FRACTION_BITS + 3;
    localparam int PROD_W = WGT_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RND_W  = ACC_W - FRACTION_BITS;

    localparam int FIX_ONE    = 1 << FRACTION_BITS;
    localparam int FIX_HALF   = 1 << (FRACTION_BITS - 1);
    localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

    // Tap sequencing
    localparam int TAPS_CUBIC  = 4;
    localparam int TAPS_LINEAR = 2;
    localparam int TAP_W       = $clog2(TAPS_CUBIC);
    localparam int CYC_W       = $clog2(TAPS_CUBIC + 3);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_LINE_LENGTH   = '0;
    localparam logic [LEN_W-1:0]   LINE_LENGTH_RESET = LEN_W'(1024);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REGION_OUT,
        REGION_LINEAR,
        REGION_CUBIC
    } t_region;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             wr;
        logic             load;
        logic             sq;
        logic             cube;
        logic             rd;
        logic [TAP_W-1:0] tap;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_region region;
    } t_dp_status;

endpackage

[design/ccls_if.sv]
interface ccls_req_if;
    import ccls_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [WIDX_W-1:0]          write_index;
    logic signed [SAMPLE_W-1:0] write_value;
    logic signed [POS_W-1:0]    position;

    modport source (output valid, output operation, output write_index,
                    output write_value, output position, input ready);
    modport sink   (input valid, input operation, input write_index,
                    input write_value, input position, output ready);
endinterface

interface ccls_rsp_if;
    import ccls_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] value;
    logic                       in_range;
    logic                       used_cubic;

    modport source (output valid, output value, output in_range,
                    output used_cubic, input ready);
    modport sink   (input valid, input value, input in_range,
                    input used_cubic, output ready);
endinterface

[design/ccls_ram.sv]
module ccls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: write, or read with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/ccls_ctrl.sv]
`include "cubic_convolution_line_sampler_assert.svh"

module ccls_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ccls_pkg::t_op         i_in_op,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  ccls_pkg::t_dp_status  i_status,
    output ccls_pkg::t_dp_cmd     o_cmd
);
    import ccls_pkg::*;

    t_state           r_state, n_state;
    logic [CYC_W-1:0] r_cyc, n_cyc;
    logic             r_out_v, n_out_v;
    logic [CYC_W-1:0] tap_cnt;
    logic [CYC_W-1:0] last_cyc;

    // Taps per query and the cycle at which the accumulator is final
    assign tap_cnt  = (i_status.region == REGION_CUBIC) ? CYC_W'(TAPS_CUBIC)
                                                        : CYC_W'(TAPS_LINEAR);
    assign last_cyc = tap_cnt + CYC_W'(2);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cyc   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cyc   <= n_cyc;
            r_out_v <= n_out_v;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_cyc      = r_cyc;
        n_out_v    = r_out_v;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        // Drop the result once taken
        if (r_out_v && i_out_ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_QUERY) begin
                        o_cmd.load = 1'b1;
                        n_cyc      = '0;
                        n_state    = S_RUN;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_RUN: begin
                n_cyc = r_cyc + CYC_W'(1);
                if (r_cyc == CYC_W'(0)) begin
                    o_cmd.sq = 1'b1;
                end
                if (r_cyc == CYC_W'(1)) begin
                    o_cmd.cube = 1'b1;
                end
                // One sample read per cycle, the first one along with the cube
                if (r_cyc >= CYC_W'(1) && r_cyc <= tap_cnt) begin
                    o_cmd.rd  = 1'b1;
                    o_cmd.tap = TAP_W'(r_cyc - CYC_W'(1));
                end
                if (i_status.region == REGION_OUT || r_cyc == last_cyc) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_v || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_v        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_v;

    `CCLS_ASSERT_NEXT(a_query_starts_run, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_op == OP_QUERY, r_state == S_RUN && r_cyc == '0)
    `CCLS_ASSERT_NEXT(a_done_loads_output, i_clk, i_rst_n, r_state == S_DONE && (!r_out_v || i_out_ready), r_out_v && r_state == S_IDLE)
    `CCLS_ASSERT_IMPL(a_run_bounded, i_clk, i_rst_n, r_state == S_RUN, r_cyc <= CYC_W'(TAPS_CUBIC + 2))

endmodule

[design/ccls_dp.sv]
module ccls_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ccls_pkg::t_dp_cmd                    i_cmd,
    output ccls_pkg::t_dp_status                 o_status,
    input  logic [ccls_pkg::LEN_W-1:0]           i_line_length,
    input  logic signed [ccls_pkg::POS_W-1:0]    i_position,
    input  logic [ccls_pkg::WIDX_W-1:0]          i_write_index,
    input  logic signed [ccls_pkg::SAMPLE_W-1:0] i_write_value,
    output logic                                 o_ram_we,
    output logic [ccls_pkg::ADDR_W-1:0]          o_ram_addr,
    output logic [ccls_pkg::SAMPLE_W-1:0]        o_ram_wdata,
    input  logic [ccls_pkg::SAMPLE_W-1:0]        i_ram_rdata,
    output logic signed [ccls_pkg::SAMPLE_W-1:0] o_value,
    output logic                                 o_in_range,
    output logic                                 o_used_cubic
);
    import ccls_pkg::*;

    localparam int F = FRACTION_BITS;

    // Query registers
    logic signed [INT_W-1:0]    r_l;
    logic [F-1:0]               r_a;
    logic [F:0]                 r_a2;
    logic [F:0]                 r_a3;
    t_region                    r_region;
    logic [ADDR_W-1:0]          r_last;

    // Tap pipeline
    logic                       r_rd_v;
    logic [TAP_W-1:0]           r_rd_k;
    logic                       r_pr_v;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    // Output register
    logic signed [SAMPLE_W-1:0] r_value;
    logic                       r_in_range;
    logic                       r_used_cubic;

    logic signed [INT_W-1:0]    pos_int;
    logic [LEN_W-1:0]           len_cap;
    logic signed [CMP_W-1:0]    l_ext;
    logic signed [CMP_W-1:0]    n_ext;
    t_region                    region_c;
    logic [2*F:0]               sq_full;
    logic [2*F+1:0]             cu_full;
    logic signed [WGT_W-1:0]    wa, wa2, wa3, wone, wgt;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [CMP_W-1:0]    r_l_ext;
    logic signed [CMP_W-1:0]    tap_idx;
    logic signed [CMP_W-1:0]    last_ext;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [RND_W-1:0]    rnd_q;
    logic signed [SAMPLE_W-1:0] sat_c;

    // Split the position and classify it against the effective length
    assign pos_int = i_position[POS_W-1:F];
    assign len_cap = (32'(i_line_length) > 32'(MAX_SAMPLES)) ? LEN_W'(MAX_SAMPLES)
                                                             : i_line_length;
    assign l_ext   = {{(CMP_W-INT_W){pos_int[INT_W-1]}}, pos_int};
    assign n_ext   = $signed({{(CMP_W-LEN_W){1'b0}}, len_cap});

    always_comb begin
        if (l_ext >= CMP_W'(1) && l_ext < n_ext - CMP_W'(1)) begin
            region_c = REGION_CUBIC;
        end else if (l_ext == '0 || (n_ext >= CMP_W'(1) && l_ext == n_ext - CMP_W'(1))) begin
            region_c = REGION_LINEAR;
        end else begin
            region_c = REGION_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_l      <= pos_int;
            r_a      <= i_position[F-1:0];
            r_region <= region_c;
            r_last   <= (len_cap == '0) ? '0 : ADDR_W'(len_cap - LEN_W'(1));
        end
    end

    // Square then cube of the fraction, rounded half up
    assign sq_full = (2*F+1)'(r_a) * (2*F+1)'(r_a) + (2*F+1)'(FIX_HALF);
    assign cu_full = (2*F+2)'(r_a2) * (2*F+2)'(r_a) + (2*F+2)'(FIX_HALF);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_a2 <= sq_full[2*F:F];
        end
        if (i_cmd.cube) begin
            r_a3 <= cu_full[2*F:F];
        end
    end

    // Clamp the tap index to the stored line
    assign r_l_ext  = {{(CMP_W-INT_W){r_l[INT_W-1]}}, r_l};
    assign last_ext = $signed({{(CMP_W-ADDR_W){1'b0}}, r_last});
    assign tap_idx  = r_l_ext + $signed({{(CMP_W-TAP_W){1'b0}}, i_cmd.tap})
                    - ((r_region == REGION_CUBIC) ? CMP_W'(1) : CMP_W'(0));

    always_comb begin
        if (tap_idx < 0) begin
            rd_addr = '0;
        end else if (tap_idx > last_ext) begin
            rd_addr = r_last;
        end else begin
            rd_addr = tap_idx[ADDR_W-1:0];
        end
    end

    // Memory port: writes only while idle, reads while running
    assign o_ram_we    = i_cmd.wr && (32'(i_write_index) < 32'(MAX_SAMPLES));
    assign o_ram_addr  = i_cmd.wr ? ADDR_W'(i_write_index) : rd_addr;
    assign o_ram_wdata = i_write_value;

    // Weight for the tap whose sample is on the read port
    assign wa   = $signed(WGT_W'(r_a));
    assign wa2  = $signed(WGT_W'(r_a2));
    assign wa3  = $signed(WGT_W'(r_a3));
    assign wone = $signed(WGT_W'(FIX_ONE));

    always_comb begin
        if (r_region == REGION_CUBIC) begin
            unique case (r_rd_k)
                TAP_W'(0): wgt = (wa2 <<< 1) - wa - wa3;
                TAP_W'(1): wgt = wone - (wa2 <<< 1) + wa3;
                TAP_W'(2): wgt = wa + wa2 - wa3;
                default:   wgt = wa3 - wa2;
            endcase
        end else begin
            wgt = r_rd_k[0] ? wa : (wone - wa);
        end
    end

    assign prod_c = wgt * $signed(i_ram_rdata);

    // Multiply, then accumulate one stage later
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_pr_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd;
            r_pr_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= i_cmd.tap;
        if (r_rd_v) begin
            r_prod <= prod_c;
        end
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_pr_v) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Round half up and saturate to the sample range
    assign rnd   = r_acc + ACC_W'(FIX_HALF);
    assign rnd_q = rnd[ACC_W-1:F];

    always_comb begin
        if (rnd_q > RND_W'(SAMPLE_MAX)) begin
            sat_c = SAMPLE_W'(SAMPLE_MAX);
        end else if (rnd_q < RND_W'(SAMPLE_MIN)) begin
            sat_c = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            sat_c = rnd_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_value      <= (r_region == REGION_OUT) ? '0 : sat_c;
            r_in_range   <= (r_region != REGION_OUT);
            r_used_cubic <= (r_region == REGION_CUBIC);
        end
    end

    assign o_status.region = r_region;
    assign o_value         = r_value;
    assign o_in_range      = r_in_range;
    assign o_used_cubic    = r_used_cubic;

endmodule

[design/cubic_convolution_line_sampler.sv]
// Cubic convolution line sampler. Write items (operation 0) store one signed
// 16-bit sample each and give no result. Query items (operation 1) take a
// Q16.16 position and give one result: cubic convolution over four taps in
// the interior, linear interpolation in the first and last intervals, zero
// with in_range low outside the line. A query occupies the block through its
// tap reads on the single sample memory port (one tap read per cycle) and the
// multiply and accumulate stages. A finished result waits in its own output
// register, so the next item is taken while it is still pending. The sample
// store is not cleared at reset: query only slots that have been written.
// line_length is the register at byte address 0, written over the APB port.
// The user must write it only while the block is idle; the block does not
// enforce this. Values above the store depth act as the depth.
module cubic_convolution_line_sampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ccls_req_if.sink                       i_req,
    ccls_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ccls_pkg::PADDR_W-1:0]   paddr,
    input  logic [ccls_pkg::PDATA_W-1:0]   pwdata,
    output logic [ccls_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import ccls_pkg::*;

    logic [LEN_W-1:0]    r_line_length;
    logic                reg_hit;
    t_dp_cmd             cmd;
    t_dp_status          status;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Configuration register
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_LINE_LENGTH);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? PDATA_W'(r_line_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_line_length <= pwdata[LEN_W-1:0];
        end
    end

    ccls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_op     (t_op'(i_req.operation)),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ccls_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_line_length (r_line_length),
        .i_position    (i_req.position),
        .i_write_index (i_req.write_index),
        .i_write_value (i_req.write_value),
        .o_ram_we      (ram_we),
        .o_ram_addr    (ram_addr),
        .o_ram_wdata   (ram_wdata),
        .i_ram_rdata   (ram_rdata),
        .o_value       (o_rsp.value),
        .o_in_range    (o_rsp.in_range),
        .o_used_cubic  (o_rsp.used_cubic)
    );

    ccls_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ccls_pkg::*;

    localparam logic [PADDR_W-1:0] LINE_LENGTH_ADDR = {REG_LINE_LENGTH, 2'b00};
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        t_op                        op;
        logic [WIDX_W-1:0]          slot;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [POS_W-1:0]    pos;
    } t_sampler_item;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       in_range;
        logic                       used_cubic;
    } t_sampler_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ccls_req_if req_if ();
    ccls_rsp_if rsp_if ();

    cubic_convolution_line_sampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the line and the length register
    logic signed [SAMPLE_W-1:0] line_samples [MAX_SAMPLES];
    logic [LEN_W-1:0]           cfg_line_length = LINE_LENGTH_RESET;
    bit                         slot_loaded [MAX_SAMPLES];

    t_sampler_item   pending_items [$];
    t_sampler_result due_results [$];
    int              queued_count = 0;
    int              mismatch_count = 0;
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    logic            hold_start = 1'b0;
    int              hold_left = 0;
    logic            req_taken = 1'b0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic longint eff_len();
        return (cfg_line_length > MAX_SAMPLES) ? MAX_SAMPLES : cfg_line_length;
    endfunction

    function automatic int clamp_slot(input longint idx, input longint n);
        longint last;
        last = (n > 0) ? n - 1 : 0;
        if (idx > last)
            idx = last;
        if (idx < 0)
            idx = 0;
        return int'(idx);
    endfunction

    // Pick the kernel from the integer part of the position
    function automatic t_region classify(input logic signed [POS_W-1:0] pos,
                                         input longint n, output longint l);
        l = longint'(pos) >>> FRACTION_BITS;
        if (l >= 1 && l < n - 1)
            return REGION_CUBIC;
        if (l == 0 || (n >= 1 && l == n - 1))
            return REGION_LINEAR;
        return REGION_OUT;
    endfunction

    function automatic longint tap(input longint idx, input longint n);
        return longint'(line_samples[clamp_slot(idx, n)]);
    endfunction

    // Expected result of one query against the shadow line
    function automatic t_sampler_result interpolate(input logic signed [POS_W-1:0] pos);
        longint          n, l, a, a2, a3, acc, v;
        t_region         region;
        t_sampler_result r;
        n = eff_len();
        region = classify(pos, n, l);
        a = longint'(pos) & (FIX_ONE - 1);
        r.value = '0;
        r.in_range = 1'b0;
        r.used_cubic = 1'b0;
        if (region == REGION_OUT)
            return r;
        if (region == REGION_CUBIC) begin
            a2 = (a * a + FIX_HALF) >> FRACTION_BITS;
            a3 = (a2 * a + FIX_HALF) >> FRACTION_BITS;
            acc = (2 * a2 - a - a3) * tap(l - 1, n)
                + (FIX_ONE - 2 * a2 + a3) * tap(l, n)
                + (a + a2 - a3) * tap(l + 1, n)
                + (a3 - a2) * tap(l + 2, n);
        end else begin
            acc = (FIX_ONE - a) * tap(l, n) + a * tap(l + 1, n);
        end
        // Round half up, then saturate to the sample range
        v = (acc + FIX_HALF) >>> FRACTION_BITS;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        r.value = SAMPLE_W'(v);
        r.in_range = 1'b1;
        r.used_cubic = (region == REGION_CUBIC);
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return SAMPLE_W'(SAMPLE_MAX);
            1: return SAMPLE_W'(SAMPLE_MIN);
            2: return '0;
            3: return SAMPLE_W'(-1);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly positions on and around the line, some anywhere
    function automatic logic signed [POS_W-1:0] rand_position();
        longint            n, l;
        logic [FRACTION_BITS-1:0] frac;
        n = eff_len();
        if ($urandom_range(1)) begin
            frac = FRACTION_BITS'($urandom);
        end else begin
            case ($urandom_range(2))
                0: frac = '0;
                1: frac = '1;
                default: frac = FRACTION_BITS'(FIX_HALF);
            endcase
        end
        case ($urandom_range(9))
            0: return POS_W'($urandom);
            1: begin
                case ($urandom_range(6))
                    0: l = -1;
                    1: l = 0;
                    2: l = 1;
                    3: l = n - 2;
                    4: l = n - 1;
                    5: l = n;
                    default: l = n + 1;
                endcase
            end
            default: l = (n > 1) ? longint'($urandom_range(int'(n - 1))) : 0;
        endcase
        return POS_W'((l <<< FRACTION_BITS) + longint'(frac));
    endfunction

    task automatic queue_write(input int slot, input logic signed [SAMPLE_W-1:0] sample);
        t_sampler_item it;
        it.op = OP_WRITE;
        it.slot = WIDX_W'(slot);
        it.sample = sample;
        it.pos = POS_W'($urandom);
        pending_items.push_back(it);
        slot_loaded[slot] = 1'b1;
        queued_count++;
    endtask

    // Load any tap the query would read that has never been written, then query
    task automatic queue_query(input logic signed [POS_W-1:0] pos);
        t_sampler_item it;
        longint        n, l, lo, hi;
        t_region       region;
        int            s;
        n = eff_len();
        region = classify(pos, n, l);
        if (region != REGION_OUT) begin
            lo = (region == REGION_CUBIC) ? l - 1 : l;
            hi = (region == REGION_CUBIC) ? l + 2 : l + 1;
            for (longint i = lo; i <= hi; i++) begin
                s = clamp_slot(i, n);
                if (!slot_loaded[s])
                    queue_write(s, rand_sample());
            end
        end
        it.op = OP_QUERY;
        it.slot = WIDX_W'($urandom);
        it.sample = SAMPLE_W'($urandom);
        it.pos = pos;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the length register, then read it back
    task automatic set_line_length(input int len);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, LINE_LENGTH_ADDR, PDATA_W'(len), rd);
        cfg_line_length = LEN_W'(len);
        apb_access(1'b0, LINE_LENGTH_ADDR, '0, rd);
        if (rd[LEN_W-1:0] != cfg_line_length)
            report_mismatch($sformatf("line_length reads %0d, wrote %0d",
                                      rd[LEN_W-1:0], cfg_line_length));
    endtask

    // Hold until every item is taken and every result is back
    task automatic wait_idle();
        int cycles;
        cycles = 0;
        while ((pending_items.size() != 0 || req_if.valid || due_results.size() != 0)
               && cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            cycles++;
        end
        if (cycles >= DRAIN_LIMIT) begin
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
            due_results.delete();
            pending_items.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Record each accepted item: update the line or expect a result
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            if (req_if.operation == OP_WRITE)
                line_samples[req_if.write_index] = req_if.write_value;
            else
                due_results.push_back(interpolate(req_if.position));
        end
    end

    // Offer the next pending item once the current one is taken
    always @(negedge i_clk) begin : drive_items
        t_sampler_item nxt;
        if (!i_rst_n) begin
            req_if.valid       <= 1'b0;
            req_if.operation   <= OP_WRITE;
            req_if.write_index <= '0;
            req_if.write_value <= '0;
            req_if.position    <= '0;
        end else if (req_taken || !req_if.valid) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_items.pop_front();
                req_if.operation   <= nxt.op;
                req_if.write_index <= nxt.slot;
                req_if.write_value <= nxt.sample;
                req_if.position    <= nxt.pos;
                req_if.valid       <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Count down a long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Stall the result channel at random, or for the whole hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_sampler_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d", rsp_if.value));
            end else begin
                want = due_results.pop_front();
                if (rsp_if.value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d",
                                              rsp_if.value, want.value));
                if (rsp_if.in_range !== want.in_range)
                    report_mismatch($sformatf("in_range %b, want %b",
                                              rsp_if.in_range, want.in_range));
                if (rsp_if.used_cubic !== want.used_cubic)
                    report_mismatch($sformatf("used_cubic %b, want %b",
                                              rsp_if.used_cubic, want.used_cubic));
            end
        end
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int phase_len [11];
        int goal;
        phase_len = '{2, 1024, 5, 0, 2047, 1, 37, 1024, 2, 2, 300};
        phase_len[8] = $urandom_range(1024, 2);

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Directed: extreme samples at both ends of the full-length line
        queue_write(0, SAMPLE_W'(SAMPLE_MAX));
        queue_write(1, SAMPLE_W'(SAMPLE_MIN));
        queue_write(2, SAMPLE_W'(SAMPLE_MAX));
        queue_write(3, SAMPLE_W'(SAMPLE_MIN));
        queue_write(4, '0);
        queue_write(5, SAMPLE_W'(-1));
        queue_write(1020, SAMPLE_W'(-100));
        queue_write(1021, SAMPLE_W'(100));
        queue_write(1022, SAMPLE_W'(SAMPLE_MAX));
        queue_write(1023, SAMPLE_W'(SAMPLE_MIN));
        queue_query(32'h0000_0000);
        queue_query(32'h0000_8000);
        queue_query(32'h0000_FFFF);
        queue_query(32'h0001_0000);
        queue_query(32'h0001_8000);
        queue_query(32'h0002_4000);
        queue_query(32'h03FD_FFFF);
        queue_query(32'h03FE_8000);
        queue_query(32'h03FF_C000);
        queue_query(32'h0400_0000);
        queue_query(32'hFFFF_FFFF);
        queue_query(32'h7FFF_FFFF);
        queue_query(32'h8000_0000);
        wait_idle();

        // Random phases over several lengths and idling patterns
        for (int p = 0; p < 11; p++) begin
            set_line_length(phase_len[p]);
            @(posedge i_clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            if (p == 4) begin
                @(negedge i_clk);
                hold_start = 1'b1;
                @(negedge i_clk);
                hold_start = 1'b0;
                @(posedge i_clk);
            end
            goal = queued_count + PHASE_ITEMS;
            while (queued_count < goal) begin
                if ($urandom_range(4) == 0)
                    queue_write($urandom_range(MAX_SAMPLES - 1), rand_sample());
                else
                    queue_query(rand_position());
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
